/* rtl/core/line_raster_with_depth_unit_defines.svh */
// Assertion macros for the line raster block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef LINE_RASTER_WITH_DEPTH_UNIT_DEFINES_SVH
`define LINE_RASTER_WITH_DEPTH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lrd_pkg.sv */
`timescale 1ns / 1ps

package lrd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS     = 24;
  // depth difference needs one more bit, the signed slope one more again
  localparam int DZ_BITS        = DEPTH_BITS + 1;
  localparam int SLOPE_BITS     = DZ_BITS + 1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic load;      // latch ordered endpoints
    logic setup;     // derive deltas, decision, start the divider
    logic step;      // emit one pixel and advance the walk
    logic slope_wr;  // capture the divider result
  } lrd_cmd_t;

  typedef struct packed {
    logic line_busy;
    logic div_done;
  } lrd_stat_t;

endpackage

/* rtl/core/lrd_if.sv */
`timescale 1ns / 1ps

interface lrd_in_if #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) ();
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [COORD_BITS-1:0]         start_x;
  logic signed [COORD_BITS-1:0]         start_y;
  logic signed [lrd_pkg::DEPTH_BITS-1:0] start_depth;
  logic signed [COORD_BITS-1:0]         end_x_in;
  logic signed [COORD_BITS-1:0]         end_y_in;
  logic signed [lrd_pkg::DEPTH_BITS-1:0] end_depth_in;

  modport source (
    output valid, op, start_x, start_y, start_depth, end_x_in, end_y_in, end_depth_in,
    input  ready
  );
  modport sink (
    input  valid, op, start_x, start_y, start_depth, end_x_in, end_y_in, end_depth_in,
    output ready
  );
endinterface

interface lrd_out_if #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) ();
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_BITS-1:0]         pixel_x;
  logic signed [COORD_BITS-1:0]         pixel_y;
  logic signed [lrd_pkg::DEPTH_BITS-1:0] pixel_depth;
  logic                                 last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_depth, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_depth, last,
    output ready
  );
endinterface

/* rtl/core/line_raster_with_depth_unit.sv */
// Channel  Direction  Transaction
// in_ch    sink       op, start_x/y/depth, end_x_in/y_in/depth_in
// out_ch   source     pixel_x, pixel_y, pixel_depth, last
//
// With out_ch drained, one pixel leaves per cycle.
// A load keeps in_ready low through the setup state, then the slope
// divider, which retires one quotient bit of the 25-bit depth difference a cycle.
// Reset is synchronous and leaves no line in progress; steps then give nothing.
// A pixel held by low out_ch.ready also holds in_ready low.
`timescale 1ns / 1ps

module line_raster_with_depth_unit #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lrd_in_if.sink    in_ch,
  lrd_out_if.source out_ch
);

  lrd_pkg::lrd_cmd_t  cmd;
  lrd_pkg::lrd_stat_t stat;

  lrd_ctrl u_lrd_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  lrd_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_lrd_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .start_x      (in_ch.start_x),
    .start_y      (in_ch.start_y),
    .start_depth  (in_ch.start_depth),
    .end_x_in     (in_ch.end_x_in),
    .end_y_in     (in_ch.end_y_in),
    .end_depth_in (in_ch.end_depth_in),
    .pixel_x      (out_ch.pixel_x),
    .pixel_y      (out_ch.pixel_y),
    .pixel_depth  (out_ch.pixel_depth),
    .last         (out_ch.last)
  );

endmodule

/* rtl/core/lrd_div.sv */
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module lrd_div #(
  parameter int NUM_BITS = lrd_pkg::DZ_BITS,
  parameter int DEN_BITS = lrd_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic                running_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [DEN_BITS-1:0] den_r;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem_r, quo_r[NUM_BITS-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
      end else if (running_r && (cnt_r == CNT_W'(1))) begin
        running_r <= 1'b0;
        done_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
      cnt_r <= CNT_W'(NUM_BITS);
    end else if (running_r) begin
      // shift the dividend out as the quotient shifts in
      quo_r <= {quo_r[NUM_BITS-2:0], fits};
      rem_r <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/core/lrd_datapath.sv */
`timescale 1ns / 1ps

module lrd_datapath #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lrd_pkg::lrd_cmd_t                     cmd,
  output lrd_pkg::lrd_stat_t                    stat,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [lrd_pkg::DEPTH_BITS-1:0] start_depth,
  input  logic signed [COORD_BITS-1:0]          end_x_in,
  input  logic signed [COORD_BITS-1:0]          end_y_in,
  input  logic signed [lrd_pkg::DEPTH_BITS-1:0] end_depth_in,
  output logic signed [COORD_BITS-1:0]          pixel_x,
  output logic signed [COORD_BITS-1:0]          pixel_y,
  output logic signed [lrd_pkg::DEPTH_BITS-1:0] pixel_depth,
  output logic                                  last
);

  localparam int DX_W = COORD_BITS + 1;
  localparam int SW   = COORD_BITS + 2;
  localparam int DW   = COORD_BITS + 4;
  localparam int ZB   = lrd_pkg::DEPTH_BITS;
  localparam int DZB  = lrd_pkg::DZ_BITS;
  localparam int WZB  = lrd_pkg::SLOPE_BITS;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_SHALLOW_DOWN = 2'd1,
    OCT_STEEP_UP     = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } octant_t;

  function automatic logic signed [ZB-1:0] sat_depth(input logic signed [WZB-1:0] v);
    logic [WZB-ZB:0] top;
    top = v[WZB-1:ZB-1];
    if ((top == '0) || (top == '1)) begin
      sat_depth = v[ZB-1:0];
    end else if (v[WZB-1]) begin
      sat_depth = {1'b1, {(ZB-1){1'b0}}};
    end else begin
      sat_depth = {1'b0, {(ZB-1){1'b1}}};
    end
  endfunction

  logic                         line_busy_r;
  octant_t                      octant_r;
  logic signed [COORD_BITS-1:0] walk_x_r, walk_y_r, final_x_r, final_y_r;
  logic signed [WZB-1:0]        walk_depth_r;
  logic signed [ZB-1:0]         final_depth_r;
  logic signed [DW-1:0]         decision_r;
  logic signed [SW-1:0]         step_a_r, step_b_r;
  logic signed [WZB-1:0]        slope_r;
  logic                         n_zero_r, dz_neg_r;
  logic signed [COORD_BITS-1:0] pix_x_r, pix_y_r;
  logic signed [ZB-1:0]         pix_depth_r;
  logic                         last_r;

  // load ordering
  logic                         swap;

  // setup
  logic signed [DX_W-1:0]       dx_s, dy_s, ady;
  logic signed [DW-1:0]         dxe, dye;
  logic                         shallow, dy_pos;
  logic signed [SW-1:0]         step_a_c, step_b_c;
  logic signed [DW-1:0]         dec_c;
  octant_t                      oct_c;
  logic [COORD_BITS-1:0]        n_c;
  logic signed [DZB-1:0]        dz_s;
  logic [DZB-1:0]               dz_mag;

  // divider
  logic                         div_done;
  logic [DZB-1:0]               quo;
  logic signed [WZB-1:0]        quo_ext;

  // walk
  logic                         reached;
  logic signed [DW-1:0]         sa, sb;
  logic                         dec_pos, dec_neg;
  logic signed [COORD_BITS-1:0] x_adv, y_adv;
  logic signed [DW-1:0]         dec_adv;

  assign swap = (start_x > end_x_in);

  always_comb begin
    dx_s     = {final_x_r[COORD_BITS-1], final_x_r} - {walk_x_r[COORD_BITS-1], walk_x_r};
    dy_s     = {final_y_r[COORD_BITS-1], final_y_r} - {walk_y_r[COORD_BITS-1], walk_y_r};
    ady      = dy_s[DX_W-1] ? -dy_s : dy_s;
    dxe      = {{(DW-DX_W){dx_s[DX_W-1]}}, dx_s};
    dye      = {{(DW-DX_W){dy_s[DX_W-1]}}, dy_s};
    shallow  = (dx_s >= ady);
    dy_pos   = !dy_s[DX_W-1] && (dy_s != '0);
    step_a_c = {dy_s, 1'b0};
    step_b_c = -{dx_s, 1'b0};
    if (shallow) begin
      if (dy_pos) begin
        oct_c = OCT_SHALLOW_UP;
        dec_c = {dye[DW-2:0], 1'b0} - dxe;
      end else begin
        oct_c = OCT_SHALLOW_DOWN;
        dec_c = {dye[DW-2:0], 1'b0} + dxe;
      end
      n_c = dx_s[COORD_BITS-1:0];
    end else begin
      if (dy_pos) begin
        oct_c = OCT_STEEP_UP;
        dec_c = dye - {dxe[DW-2:0], 1'b0};
      end else begin
        oct_c = OCT_STEEP_DOWN;
        dec_c = dye + {dxe[DW-2:0], 1'b0};
      end
      n_c = ady[COORD_BITS-1:0];
    end
    dz_s   = {final_depth_r[ZB-1], final_depth_r} - walk_depth_r[DZB-1:0];
    dz_mag = dz_s[DZB-1] ? -dz_s : dz_s;
  end

  lrd_div #(
    .NUM_BITS (DZB),
    .DEN_BITS (COORD_BITS)
  ) u_lrd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.setup),
    .dividend (dz_mag),
    .divisor  (n_c),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_ext = {1'b0, quo};

  always_comb begin
    reached = (octant_r == OCT_SHALLOW_UP || octant_r == OCT_SHALLOW_DOWN) ?
              (walk_x_r == final_x_r) : (walk_y_r == final_y_r);
    sa      = {{(DW-SW){step_a_r[SW-1]}}, step_a_r};
    sb      = {{(DW-SW){step_b_r[SW-1]}}, step_b_r};
    dec_pos = !decision_r[DW-1] && (decision_r != '0);
    dec_neg = decision_r[DW-1];
    x_adv   = walk_x_r;
    y_adv   = walk_y_r;
    case (octant_r)
      OCT_SHALLOW_UP: begin
        x_adv = walk_x_r + COORD_BITS'(1);
        if (dec_pos) begin
          y_adv   = walk_y_r + COORD_BITS'(1);
          dec_adv = decision_r + sb + sa;
        end else begin
          dec_adv = decision_r + sa;
        end
      end
      OCT_SHALLOW_DOWN: begin
        x_adv = walk_x_r + COORD_BITS'(1);
        if (dec_neg) begin
          y_adv   = walk_y_r - COORD_BITS'(1);
          dec_adv = decision_r - sb + sa;
        end else begin
          dec_adv = decision_r + sa;
        end
      end
      OCT_STEEP_UP: begin
        y_adv = walk_y_r + COORD_BITS'(1);
        if (dec_neg) begin
          x_adv   = walk_x_r + COORD_BITS'(1);
          dec_adv = decision_r + sa + sb;
        end else begin
          dec_adv = decision_r + sb;
        end
      end
      default: begin
        y_adv = walk_y_r - COORD_BITS'(1);
        if (dec_pos) begin
          x_adv   = walk_x_r + COORD_BITS'(1);
          dec_adv = decision_r + sa - sb;
        end else begin
          dec_adv = decision_r - sb;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_busy_r <= 1'b0;
    end else if (cmd.load) begin
      line_busy_r <= 1'b1;
    end else if (cmd.step && reached) begin
      line_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // order by x; equal x keeps the given order
      walk_x_r      <= swap ? end_x_in : start_x;
      walk_y_r      <= swap ? end_y_in : start_y;
      walk_depth_r  <= swap ? WZB'(end_depth_in) : WZB'(start_depth);
      final_x_r     <= swap ? start_x : end_x_in;
      final_y_r     <= swap ? start_y : end_y_in;
      final_depth_r <= swap ? start_depth : end_depth_in;
    end else if (cmd.step && !reached) begin
      walk_x_r      <= x_adv;
      walk_y_r      <= y_adv;
      walk_depth_r  <= walk_depth_r + slope_r;
      decision_r    <= dec_adv;
    end

    if (cmd.setup) begin
      octant_r   <= oct_c;
      decision_r <= dec_c;
      step_a_r   <= step_a_c;
      step_b_r   <= step_b_c;
      n_zero_r   <= (n_c == '0);
      dz_neg_r   <= dz_s[DZB-1];
    end

    if (cmd.slope_wr) begin
      slope_r <= n_zero_r ? '0 : (dz_neg_r ? -quo_ext : quo_ext);
    end

    if (cmd.step) begin
      if (reached) begin
        pix_x_r     <= final_x_r;
        pix_y_r     <= final_y_r;
        pix_depth_r <= final_depth_r;
        last_r      <= 1'b1;
      end else begin
        pix_x_r     <= walk_x_r;
        pix_y_r     <= walk_y_r;
        pix_depth_r <= sat_depth(walk_depth_r);
        last_r      <= 1'b0;
      end
    end
  end

  assign stat.line_busy = line_busy_r;
  assign stat.div_done  = div_done;
  assign pixel_x        = pix_x_r;
  assign pixel_y        = pix_y_r;
  assign pixel_depth    = pix_depth_r;
  assign last           = last_r;

endmodule

/* rtl/core/lrd_ctrl.sv */
`timescale 1ns / 1ps

module lrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output lrd_pkg::lrd_cmd_t  cmd,
  input  lrd_pkg::lrd_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_DIV   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_comb begin
    in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    accept       = in_valid && in_ready;
    cmd.load     = accept && (in_op == lrd_pkg::OP_LOAD);
    // a step with no line in progress is dropped
    cmd.step     = accept && (in_op == lrd_pkg::OP_STEP) && stat.line_busy;
    cmd.setup    = (state_r == S_SETUP);
    cmd.slope_wr = (state_r == S_DIV) && stat.div_done;

    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.load) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_DIV;
      S_DIV:   if (stat.div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/lrd_checker.sv */
`timescale 1ns / 1ps
`include "line_raster_with_depth_unit_defines.svh"

module lrd_checker #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_op,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [COORD_BITS-1:0]          out_pixel_x,
  input logic signed [COORD_BITS-1:0]          out_pixel_y,
  input logic signed [lrd_pkg::DEPTH_BITS-1:0] out_pixel_depth,
  input logic                                  out_last
);

  `LRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_pixel_depth) && $stable(out_last), "pixel changed while stalled")
  `LRD_ASSERT_NOW(a_out_from_step, $rose(out_valid), $past(in_valid && in_ready && in_op == lrd_pkg::OP_STEP), "pixel without a step transaction")
  `LRD_ASSERT_NEXT(a_load_blocks, in_valid && in_ready && in_op == lrd_pkg::OP_LOAD, !in_ready && !out_valid, "load did not enter setup")
  `LRD_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken over a held pixel")

endmodule

bind line_raster_with_depth_unit lrd_checker #(
  .COORD_BITS (COORD_BITS)
) u_lrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_depth (out_ch.pixel_depth),
  .out_last        (out_ch.last)
);
